// ----- hdl/prle_pkg.sv -----
// shared types, constants and result builders for the palette run-length encoder
// no dependencies; imported by every module in hdl/
package prle_pkg;

  localparam int RGB_W            = 24;
  localparam int DEF_PALETTE_SIZE = 256;
  localparam int DEF_MAX_RUN      = 4096;

  // result kinds
  localparam logic [1:0] KIND_NEW = 2'd0;
  localparam logic [1:0] KIND_RUN = 2'd1;
  localparam logic [1:0] KIND_OVF = 2'd2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
    logic       image_start;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  color_index;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [12:0] run_length;
    logic        last_result;
  } out_word_t;

  // search unit status toward the sequencer
  typedef struct packed {
    logic done;
    logic found;
  } search_stat_t;

  function automatic out_word_t make_run(logic [31:0] idx, logic [31:0] len);
    out_word_t w;
    w             = '0;
    w.kind        = KIND_RUN;
    w.color_index = idx[7:0];
    w.run_length  = len[12:0];
    return w;
  endfunction

  function automatic out_word_t make_new(logic [31:0] idx, logic [RGB_W-1:0] rgb);
    out_word_t w;
    w             = '0;
    w.kind        = KIND_NEW;
    w.color_index = idx[7:0];
    w.out_red     = rgb[23:16];
    w.out_green   = rgb[15:8];
    w.out_blue    = rgb[7:0];
    return w;
  endfunction

  function automatic out_word_t make_ovf();
    out_word_t w;
    w      = '0;
    w.kind = KIND_OVF;
    return w;
  endfunction

endpackage

// ----- hdl/prle_palette_ram.sv -----
// palette storage: one write port, one registered read port
// depends on prle_pkg
module prle_palette_ram #(
  parameter int DEPTH = 256
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [$clog2(DEPTH)-1:0]  wr_addr,
  input  logic [prle_pkg::RGB_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [$clog2(DEPTH)-1:0]  rd_addr,
  output logic [prle_pkg::RGB_W-1:0] rd_data
);
  import prle_pkg::*;

  logic [RGB_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- hdl/prle_search_unit.sv -----
// sequential palette search: one entry compared per cycle, reads pipelined
// depends on prle_pkg; drives the read port of prle_palette_ram
module prle_search_unit #(
  parameter int PALETTE_SIZE = prle_pkg::DEF_PALETTE_SIZE
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [prle_pkg::RGB_W-1:0]           start_rgb,
  input  logic [$clog2(PALETTE_SIZE+1)-1:0]    start_lim,
  output logic                                 rd_en,
  output logic [$clog2(PALETTE_SIZE)-1:0]      rd_addr,
  input  logic [prle_pkg::RGB_W-1:0]           rd_data,
  output prle_pkg::search_stat_t               status,
  output logic [$clog2(PALETTE_SIZE)-1:0]      hit_idx
);
  import prle_pkg::*;

  localparam int IDX_W  = $clog2(PALETTE_SIZE);
  localparam int USED_W = $clog2(PALETTE_SIZE + 1);

  logic              busy_r;
  logic              pend_r;
  logic [USED_W-1:0] issue_r;
  logic [IDX_W-1:0]  pend_idx_r;
  logic [RGB_W-1:0]  rgb_r;
  logic [USED_W-1:0] lim_r;
  logic              done_r;
  logic              found_r;
  logic [IDX_W-1:0]  idx_r;

  logic              more;
  logic              hit;

  assign more    = issue_r < lim_r;
  assign hit     = pend_r && (rd_data == rgb_r);
  assign rd_en   = busy_r && more;
  assign rd_addr = issue_r[IDX_W-1:0];

  assign status.done  = done_r;
  assign status.found = found_r;
  assign hit_idx      = idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      pend_r  <= 1'b0;
      done_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      if (start) begin
        busy_r  <= 1'b1;
        pend_r  <= 1'b0;
        done_r  <= 1'b0;
        issue_r <= '0;
        rgb_r   <= start_rgb;
        lim_r   <= start_lim;
      end else if (busy_r) begin
        if (hit) begin
          busy_r  <= 1'b0;
          pend_r  <= 1'b0;
          done_r  <= 1'b1;
          found_r <= 1'b1;
          idx_r   <= pend_idx_r;
        end else if (!pend_r && !more) begin
          busy_r  <= 1'b0;
          done_r  <= 1'b1;
          found_r <= 1'b0;
        end else begin
          done_r     <= 1'b0;
          pend_r     <= more;
          pend_idx_r <= issue_r[IDX_W-1:0];
          if (more) begin
            issue_r <= issue_r + USED_W'(1);
          end
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/palette_rle_encoder_unit.sv -----
// palette run-length encoder top level: sequencer, run state, result queue
// depends on prle_pkg, prle_palette_ram and prle_search_unit
//
// usage
//   in channel (in_valid/in_ready/in_data): one rgb pixel word per handshake,
//   raster order, with row_end on the last pixel of a row and image_start on
//   the first pixel of an image (clears the palette, flushes an open run).
//   out channel (out_valid/out_ready/out_data): zero to three result words per
//   pixel - new palette entry, completed run or palette overflow - with
//   last_result set on the final word of each pixel.
// timing
//   a pixel is taken only in idle; the palette is then searched one entry per
//   cycle through the search unit and the registered ram read port, over the
//   used entries only (at most PALETTE_SIZE); result words then leave in order,
//   one per cycle while out_ready is high.
// reset
//   synchronous, active low: palette count, run state and both channels clear;
//   palette contents are not cleared, only entries below the count are read.
// stalls
//   result words sit in an output register; a stalled receiver holds the
//   sequencer in drain, and the last word may still wait while the next pixel
//   is accepted and searched.
module palette_rle_encoder_unit #(
  parameter int PALETTE_SIZE = prle_pkg::DEF_PALETTE_SIZE,
  parameter int MAX_RUN      = prle_pkg::DEF_MAX_RUN
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  prle_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output prle_pkg::out_word_t out_data
);
  import prle_pkg::*;

  localparam int IDX_W  = $clog2(PALETTE_SIZE);
  localparam int USED_W = $clog2(PALETTE_SIZE + 1);
  localparam int CNT_W  = $clog2(MAX_RUN + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DRAIN
  } state_t;

  state_t            state_r;
  in_word_t          pix_r;
  logic [USED_W-1:0] used_r;
  logic [IDX_W-1:0]  run_color_r;
  logic [CNT_W-1:0]  run_count_r;
  logic              run_open_r;
  out_word_t         q_r [3];
  logic [1:0]        q_cnt_r;
  logic [1:0]        q_pos_r;
  logic              out_valid_r;
  out_word_t         out_data_r;

  // search side
  logic              accept;
  logic [RGB_W-1:0]  in_rgb;
  logic [USED_W-1:0] start_lim;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [RGB_W-1:0]  rd_data;
  search_stat_t      sstat;
  logic [IDX_W-1:0]  hit_idx;

  // decision results
  logic [USED_W-1:0] used_eff;
  logic [RGB_W-1:0]  pix_rgb;
  out_word_t         q_nxt [3];
  logic [1:0]        n_nxt;
  logic [USED_W-1:0] used_nxt;
  logic [IDX_W-1:0]  color_nxt;
  logic [CNT_W-1:0]  count_nxt;
  logic              open_nxt;
  logic              wr_en;

  // drain side
  logic              can_load;
  out_word_t         load_word;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign in_rgb    = {in_data.red, in_data.green, in_data.blue};
  assign start_lim = in_data.image_start ? '0 : used_r;

  assign used_eff  = pix_r.image_start ? '0 : used_r;
  assign pix_rgb   = {pix_r.red, pix_r.green, pix_r.blue};

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  prle_palette_ram #(
    .DEPTH (PALETTE_SIZE)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (used_eff[IDX_W-1:0]),
    .wr_data (pix_rgb),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  prle_search_unit #(
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_search (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .start_rgb (in_rgb),
    .start_lim (start_lim),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .status    (sstat),
    .hit_idx   (hit_idx)
  );

  // run and palette update once the search has finished, results in order:
  // flush at image start, close on index change, new entry or overflow,
  // close on full run or row end
  always_comb begin
    logic [IDX_W-1:0] idx;
    logic             have;
    logic             fresh;
    for (int k = 0; k < 3; k++) begin
      q_nxt[k] = '0;
    end
    n_nxt     = '0;
    used_nxt  = used_eff;
    color_nxt = run_color_r;
    count_nxt = run_count_r;
    open_nxt  = run_open_r;
    idx       = hit_idx;
    have      = sstat.found;
    fresh     = 1'b0;

    if (pix_r.image_start && open_nxt) begin
      q_nxt[n_nxt] = make_run(32'(color_nxt), 32'(count_nxt));
      n_nxt        = n_nxt + 2'd1;
      open_nxt     = 1'b0;
      count_nxt    = '0;
    end

    if (!have) begin
      if (used_eff == USED_W'(PALETTE_SIZE)) begin
        q_nxt[n_nxt] = make_ovf();
        n_nxt        = n_nxt + 2'd1;
      end else begin
        idx      = used_eff[IDX_W-1:0];
        used_nxt = used_eff + USED_W'(1);
        have     = 1'b1;
        fresh    = 1'b1;
      end
    end

    if (have) begin
      if (open_nxt && (color_nxt != idx)) begin
        q_nxt[n_nxt] = make_run(32'(color_nxt), 32'(count_nxt));
        n_nxt        = n_nxt + 2'd1;
        open_nxt     = 1'b0;
        count_nxt    = '0;
      end
      if (fresh) begin
        q_nxt[n_nxt] = make_new(32'(idx), pix_rgb);
        n_nxt        = n_nxt + 2'd1;
      end
      if (open_nxt) begin
        count_nxt = count_nxt + CNT_W'(1);
      end else begin
        open_nxt  = 1'b1;
        color_nxt = idx;
        count_nxt = CNT_W'(1);
      end
      if (count_nxt >= CNT_W'(MAX_RUN)) begin
        q_nxt[n_nxt] = make_run(32'(color_nxt), 32'(count_nxt));
        n_nxt        = n_nxt + 2'd1;
        open_nxt     = 1'b0;
        count_nxt    = '0;
      end
    end

    if (pix_r.row_end && open_nxt) begin
      q_nxt[n_nxt] = make_run(32'(color_nxt), 32'(count_nxt));
      n_nxt        = n_nxt + 2'd1;
      open_nxt     = 1'b0;
      count_nxt    = '0;
    end

    wr_en = (state_r == S_SEARCH) && sstat.done && fresh;
  end

  // next queued word goes to the output register when that slot frees up
  assign can_load = (q_pos_r < q_cnt_r) && (!out_valid_r || out_ready);

  always_comb begin
    load_word             = q_r[q_pos_r];
    load_word.last_result = ((q_pos_r + 2'd1) == q_cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      run_color_r <= '0;
      run_count_r <= '0;
      run_open_r  <= 1'b0;
      q_cnt_r     <= '0;
      q_pos_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // output register fills from the queue, else empties on a taken word
      if ((state_r == S_DRAIN) && can_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            pix_r   <= in_data;
            state_r <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (sstat.done) begin
            used_r      <= used_nxt;
            run_color_r <= color_nxt;
            run_count_r <= count_nxt;
            run_open_r  <= open_nxt;
            q_r         <= q_nxt;
            q_cnt_r     <= n_nxt;
            q_pos_r     <= '0;
            state_r     <= (n_nxt == 2'd0) ? S_IDLE : S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (can_load) begin
            out_data_r  <= load_word;
            q_pos_r     <= q_pos_r + 2'd1;
            if ((q_pos_r + 2'd1) == q_cnt_r) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
